FILE: sv/glyph_text_layout_assert.svh
// Assertion macros shared by the glyph text layout modules.
`ifndef GLYPH_TEXT_LAYOUT_ASSERT_SVH
`define GLYPH_TEXT_LAYOUT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons holds too.
`define GLT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph_text_layout: assertion failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define GLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph_text_layout: assertion failed");
`else
`define GLT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GLT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/glt_pkg.sv
// Types and constants shared by the glyph text layout modules.
package glt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] END_CODE     = 8'd0;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_TEXT     = 1'b1;
   localparam logic KIND_GLYPH  = 1'b0;
   localparam logic KIND_EXTENT = 1'b1;

   typedef enum logic [1:0] {
      CSR_LEFT_EDGE   = 2'd0,
      CSR_TOP_EDGE    = 2'd1,
      CSR_ASCENT      = 2'd2,
      CSR_LINE_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_IGNORE,
      CLS_GLYPH,
      CLS_NEWLINE,
      CLS_END
   } char_class_type;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        char_code;
      logic [7:0]        advance;
      logic signed [7:0] left_bearing;
      logic signed [7:0] top_bearing;
      logic [7:0]        glyph_width;
      logic [7:0]        glyph_height;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  glyph_code;
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] x1;
      logic [15:0] y1;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        advance;
      logic signed [7:0] left_bearing;
      logic signed [7:0] top_bearing;
      logic [7:0]        glyph_width;
      logic [7:0]        glyph_height;
   } glyph_metrics_type;

   typedef struct packed {
      char_class_type    cls;
      logic [7:0]        code;
      glyph_metrics_type metrics;
   } queue_entry_type;

   typedef struct packed {
      logic [15:0] left_edge;
      logic [15:0] top_edge;
      logic [7:0]  ascent;
      logic [7:0]  line_height;
   } csr_type;

endpackage

FILE: sv/glt_front.sv
// Front end: accepts items, maintains the glyph table and classifies characters.
`include "glyph_text_layout_assert.svh"

module glt_front import glt_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   input  logic [QCOUNT_BITS-1:0] q_count,
   output logic                   q_push,
   output queue_entry_type        q_data
);

   localparam int         IDX_BITS   = $clog2(TABLE_ENTRIES);
   localparam logic [8:0] CODE_LIMIT = 9'(TABLE_ENTRIES);

   logic              valid_ff [TABLE_ENTRIES];
   glyph_metrics_type table_mem [TABLE_ENTRIES];
   glyph_metrics_type rd_ff;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [7:0]        s1_code_ff;
   logic              s1_hit_ff;

   logic                 accept;
   logic                 in_range;
   logic [IDX_BITS-1:0]  idx;
   logic                 load_en;
   logic                 text_en;
   logic [QCOUNT_BITS:0] occupancy;
   glyph_metrics_type    wr_metrics;
   char_class_type       cls;

   // The character in flight always gets a queue slot next cycle.
   assign occupancy = {1'b0, q_count} + (QCOUNT_BITS + 1)'(s1_valid_ff);
   assign full      = occupancy >= (QCOUNT_BITS + 1)'(QUEUE_DEPTH);

   assign accept   = push && !full;
   assign in_range = {1'b0, req_data.char_code} < CODE_LIMIT;
   assign idx      = req_data.char_code[IDX_BITS-1:0];
   assign load_en  = accept && (req_data.opcode == OP_LOAD) && in_range;
   assign text_en  = accept && (req_data.opcode == OP_TEXT);
   assign s1_valid_in = text_en;

   assign wr_metrics = '{advance:      req_data.advance,
                         left_bearing: req_data.left_bearing,
                         top_bearing:  req_data.top_bearing,
                         glyph_width:  req_data.glyph_width,
                         glyph_height: req_data.glyph_height};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (load_en) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         table_mem[idx] <= wr_metrics;
      end
      if (text_en) begin
         rd_ff <= table_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (text_en) begin
         s1_code_ff <= req_data.char_code;
         s1_hit_ff  <= in_range && valid_ff[idx];
      end
   end

   always_comb begin
      if (s1_code_ff == END_CODE) begin
         cls = CLS_END;
      end else if (s1_hit_ff) begin
         cls = CLS_GLYPH;
      end else if (s1_code_ff == NEWLINE_CODE) begin
         cls = CLS_NEWLINE;
      end else begin
         cls = CLS_IGNORE;
      end
   end

   assign q_push = s1_valid_ff;
   assign q_data = '{cls: cls, code: s1_code_ff, metrics: rd_ff};

   `GLT_ASSERT_IMP(a_queue_no_overflow, clock, reset, s1_valid_ff,
                   q_count != QCOUNT_BITS'(QUEUE_DEPTH))
   `GLT_ASSERT_NEXT(a_text_follows_stage, clock, reset, text_en, s1_valid_ff)

endmodule

FILE: sv/glt_queue.sv
// Short queue of classified characters between the front and back ends.
module glt_queue import glt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  queue_entry_type        push_data,
   input  logic                   pop,
   output queue_entry_type        pop_data,
   output logic                   nonempty,
   output logic [QCOUNT_BITS-1:0] count
);

   queue_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QCOUNT_BITS-1:0] count_in;
   logic                   do_pop;

   assign nonempty = count_ff != '0;
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push_valid);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(do_pop);
      count_in  = count_ff + QCOUNT_BITS'(push_valid) - QCOUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/glt_back.sv
// Back end: pen and baseline tracking, quad and extent results, result register.
`include "glyph_text_layout_assert.svh"

module glt_back import glt_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  csr_type         cfg,
   input  logic            q_nonempty,
   input  queue_entry_type q_data,
   output logic            q_pop,
   output logic            empty,
   input  logic            pop,
   output rsp_type         rsp_data
);

   localparam int C = COORD_BITS;

   logic [C-1:0] pen_ff,    pen_in;
   logic [C-1:0] base_ff,   base_in;
   logic [C-1:0] widest_ff, widest_in;
   logic [C-1:0] height_ff, height_in;
   logic         start_ff,  start_in;
   logic [C-1:0] base_start_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic [C-1:0] left, top, lh;
   logic [C-1:0] pen_e, base_e;
   logic [C-1:0] qx, qy, line_w, ext_w, ext_h;
   logic         produces, slot_free, take;

   assign left = cfg.left_edge[C-1:0];
   assign top  = cfg.top_edge[C-1:0];
   assign lh   = C'(cfg.line_height);

   // Configuration must only change when idle (unenforced); first baseline registered.
   always_ff @(posedge clock) begin
      base_start_ff <= top + C'(cfg.ascent);
   end

   assign pen_e  = start_ff ? left : pen_ff;
   assign base_e = start_ff ? base_start_ff : base_ff;

   assign produces  = (q_data.cls == CLS_GLYPH) || (q_data.cls == CLS_END);
   assign slot_free = !rsp_valid_ff || pop;
   assign take      = q_nonempty && (slot_free || !produces);
   assign q_pop     = take;

   always_comb begin
      qx     = pen_e + C'(q_data.metrics.left_bearing);
      qy     = base_e - C'(q_data.metrics.top_bearing);
      line_w = pen_e - left;
      ext_w  = (widest_ff == '0 && line_w != '0) ? line_w : widest_ff;
      ext_h  = (ext_w != '0 && height_ff == '0) ? lh : height_ff;

      pen_in       = pen_ff;
      base_in      = base_ff;
      widest_in    = widest_ff;
      height_in    = height_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_data_in  = rsp_data_ff;

      if (take) begin
         pen_in   = pen_e;
         base_in  = base_e;
         start_in = 1'b0;
         case (q_data.cls)
            CLS_GLYPH: begin
               pen_in       = pen_e + C'(q_data.metrics.advance);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind:       KIND_GLYPH,
                                glyph_code: q_data.code,
                                x0:         16'(qx),
                                y0:         16'(qy),
                                x1:         16'(qx + C'(q_data.metrics.glyph_width)),
                                y1:         16'(qy + C'(q_data.metrics.glyph_height))};
            end
            CLS_END: begin
               widest_in    = '0;
               height_in    = '0;
               start_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{kind:       KIND_EXTENT,
                                glyph_code: END_CODE,
                                x0:         16'(left),
                                y0:         16'(top),
                                x1:         16'(left + ext_w),
                                y1:         16'(top + ext_h)};
            end
            CLS_NEWLINE: begin
               base_in   = base_e + lh;
               height_in = height_ff + lh;
               widest_in = (line_w > widest_ff) ? line_w : widest_ff;
               pen_in    = left;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= '0;
         base_ff      <= '0;
         widest_ff    <= '0;
         height_ff    <= '0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_ff       <= pen_in;
         base_ff      <= base_in;
         widest_ff    <= widest_in;
         height_ff    <= height_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `GLT_ASSERT_NEXT(a_restart_after_end, clock, reset, take && (q_data.cls == CLS_END),
                    start_ff && (widest_ff == '0) && (height_ff == '0))
   `GLT_ASSERT_NEXT(a_result_registered, clock, reset, take && produces, rsp_valid_ff)

endmodule

FILE: sv/glyph_text_layout.sv
// Top level of the glyph text layout block: registers, front end, queue and back end.
//
// Text layout engine. Items enter through a queue-style port (push/full): a load
// item writes the metrics of one character code into a direct-indexed glyph table
// (a later load to the same code replaces the earlier one); a text item is placed
// using that table. A character with a valid entry yields a glyph quad and advances
// the pen; a newline without an entry steps the baseline down by line_height and
// returns the pen to left_edge; code 0 ends the text and yields the extent result,
// then layout restarts at the next character. Results leave through a queue-style
// port (empty/pop). One item is accepted every cycle while the internal queue has
// room; a text item passes the table read on the accepting edge, the queue write
// and the back end before it reaches the result register, and the back end
// retires one character per cycle unless a result waits for the result register.
// Table valid bits clear at reset, so the block takes items from the first cycle
// after reset. Configuration registers (left_edge, top_edge, ascent, line_height)
// should only be written while no transaction is in flight. Coordinates wrap
// modulo 2^COORD_BITS and are returned zero-extended to 16 bits.
module glyph_text_layout import glt_pkg::*; #(
   parameter int TABLE_ENTRIES = 256,
   parameter int COORD_BITS    = 16
) (
   input  logic          clock,
   input  logic          reset,
   // input transactions
   input  logic          push,
   output logic          full,
   input  req_type       req_data,
   // result transactions
   output logic          empty,
   input  logic          pop,
   output rsp_type       rsp_data,
   // configuration writes
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   csr_type                csr_ff;
   csr_type                csr_in;

   logic                   q_push;
   queue_entry_type        q_push_data;
   logic                   q_pop;
   queue_entry_type        q_pop_data;
   logic                   q_nonempty;
   logic [QCOUNT_BITS-1:0] q_count;

   // Decode the register write; narrower registers take the low bits.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LEFT_EDGE:   csr_in.left_edge   = csr_wdata;
            CSR_TOP_EDGE:    csr_in.top_edge    = csr_wdata;
            CSR_ASCENT:      csr_in.ascent      = csr_wdata[7:0];
            CSR_LINE_HEIGHT: csr_in.line_height = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front end: hold the glyph table, read it for each character, classify.
   glt_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // Decouple the two halves so that a stalled result does not block loads until the queue fills.
   glt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .pop_data   (q_pop_data),
      .nonempty   (q_nonempty),
      .count      (q_count)
   );

   // Back end: advance the pen, track line extents, drive the result register.
   glt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (csr_ff),
      .q_nonempty (q_nonempty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
